>>> hdl/kuat_pkg.sv
// kuat_pkg: shared types and constants for the keyed usage accumulator table
// no dependencies
package kuat_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int NameW = 36;
	localparam int TimeInW = 24;
	localparam int CountW = 32;
	localparam int TotalW = 48;
	localparam int EntryW = NameW + CountW + CountW + TotalW;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_READOUT  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		logic [NameW-1:0]  name;
		logic [CountW-1:0] runs;
		logic [CountW-1:0] timed;
		logic [TotalW-1:0] total;
	} entry_t;

	// request from the sequencer to the table memory
	typedef struct packed {
		logic             rd_en;
		logic [IdxW-1:0]  rd_addr;
		logic             wr_en;
		logic [IdxW-1:0]  wr_addr;
		entry_t           wr_data;
	} mem_req_t;
endpackage

>>> hdl/kuat_mem.sv
// kuat_mem: single-port-read, single-port-write entry store with a registered read
// depends on kuat_pkg
module kuat_mem (
	input  logic               clk,
	input  kuat_pkg::mem_req_t req,
	output kuat_pkg::entry_t   rd_data
);
	import kuat_pkg::*;

	entry_t mem [TableDepth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

>>> hdl/kuat_seq.sv
// kuat_seq: search, update, exchange sort and readout sequencer
// depends on kuat_pkg; drives kuat_mem
module kuat_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic [kuat_pkg::NameW-1:0]   in_name,
	input  logic [kuat_pkg::TimeInW-1:0] in_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output kuat_pkg::status_t            out_status,
	output kuat_pkg::entry_t             out_entry,
	output logic                         out_last,
	output kuat_pkg::mem_req_t           req,
	input  kuat_pkg::entry_t             rd_data
);
	import kuat_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SRCH  = 10'b0000000010,
		S_UPD   = 10'b0000000100,
		S_SRDI  = 10'b0000001000,
		S_SRDJ  = 10'b0000010000,
		S_SCMP  = 10'b0000100000,
		S_SWAP  = 10'b0001000000,
		S_OUTRD = 10'b0010000000,
		S_OUTW  = 10'b0100000000,
		S_EMPTY = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   used_q;
	logic [CntW-1:0]   i_q;
	logic [CntW-1:0]   j_q;
	logic [NameW-1:0]  name_q;
	logic [TimeInW-1:0] time_q;
	entry_t            ei_q;
	entry_t            ej_q;
	logic              pend_q;
	logic              upd_found_q;

	logic              found;
	logic              at_end;
	logic              out_free;
	logic              emit;
	entry_t            base;
	entry_t            upd;
	logic [TotalW:0]   sum;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;
	assign found = pend_q && (rd_data.name == name_q);
	assign at_end = (j_q == used_q);

	// saturating update of the located or fresh entry
	always_comb begin
		base = upd_found_q ? rd_data : '{name: name_q, runs: '0, timed: '0, total: '0};
		upd = base;
		if (base.runs != '1) upd.runs = base.runs + 1'b1;
		if (time_q != '0 && base.timed != '1) upd.timed = base.timed + 1'b1;
		sum = {1'b0, base.total} + {{(TotalW + 1 - TimeInW){1'b0}}, time_q};
		upd.total = sum[TotalW] ? '1 : sum[TotalW-1:0];
	end

	// memory request
	always_comb begin
		req = '0;
		case (state_q)
			S_SRCH: begin
				req.rd_en = !found && !at_end;
				req.rd_addr = j_q[IdxW-1:0];
			end
			S_SRDI: begin
				req.rd_en = 1'b1;
				req.rd_addr = i_q[IdxW-1:0];
			end
			S_SRDJ: begin
				req.rd_en = 1'b1;
				req.rd_addr = j_q[IdxW-1:0];
			end
			S_SCMP: begin
				req.rd_en = 1'b0;
			end
			S_SWAP: begin
				req.wr_en = 1'b1;
				req.wr_addr = j_q[IdxW-1:0];
				req.wr_data = ei_q;
			end
			S_UPD: begin
				req.wr_en = 1'b1;
				req.wr_addr = i_q[IdxW-1:0];
				req.wr_data = upd;
			end
			S_OUTRD: begin
				req.rd_en = 1'b1;
				req.rd_addr = i_q[IdxW-1:0];
			end
			default: req = '0;
		endcase
		// exchange: write i with j's value in the compare cycle
		if (state_q == S_SCMP && rd_data.total > ei_q.total) begin
			req.wr_en = 1'b1;
			req.wr_addr = i_q[IdxW-1:0];
			req.wr_data = rd_data;
		end
	end

	// result beat loaded into the output register this cycle
	always_comb begin
		case (state_q)
			S_EMPTY, S_UPD: emit = out_free;
			S_SRCH: emit = out_free && !found && at_end && (used_q == CntW'(TableDepth));
			S_OUTW: emit = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			pend_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			name_q <= '0;
			time_q <= '0;
			ei_q <= '0;
			ej_q <= '0;
			out_status <= ST_UPDATED;
			out_entry <= '0;
			out_last <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						name_q <= in_name;
						time_q <= in_time;
						j_q <= '0;
						i_q <= '0;
						pend_q <= 1'b0;
						if (!in_op) begin
							state_q <= S_SRCH;
						end else if (used_q == '0) begin
							state_q <= S_EMPTY;
						end else begin
							state_q <= S_SRDI;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
						out_status <= ST_EMPTY;
						out_entry <= '0;
						out_last <= 1'b1;
					end
				end
				S_SRCH: begin
					// j_q is the next address to read; i_q is the one in flight
					if (found) begin
						state_q <= S_UPD;
						pend_q <= 1'b0;
					end else if (at_end) begin
						pend_q <= 1'b0;
						if (used_q == CntW'(TableDepth)) begin
							if (out_free) begin
								state_q <= S_IDLE;
								out_status <= ST_FULL;
								out_entry <= '{name: name_q, runs: '0, timed: '0, total: '0};
								out_last <= 1'b1;
							end
						end else begin
							i_q <= used_q;
							state_q <= S_UPD;
						end
					end else begin
						pend_q <= 1'b1;
						i_q <= j_q;
						j_q <= j_q + 1'b1;
					end
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
						out_status <= upd_found_q ? ST_UPDATED : ST_INSERTED;
						out_entry <= upd;
						out_last <= 1'b1;
						if (!upd_found_q) used_q <= used_q + 1'b1;
					end
				end
				S_SRDI: begin
					if (i_q + 1'b1 >= used_q) begin
						i_q <= '0;
						state_q <= S_OUTRD;
					end else begin
						j_q <= i_q + 1'b1;
						state_q <= S_SRDJ;
					end
				end
				S_SRDJ: begin
					if (j_q == i_q + 1'b1) ei_q <= rd_data;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (rd_data.total > ei_q.total) begin
						ej_q <= rd_data;
						state_q <= S_SWAP;
					end else if (j_q + 1'b1 == used_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SRDI;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_SRDJ;
					end
				end
				S_SWAP: begin
					ei_q <= ej_q;
					if (j_q + 1'b1 == used_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SRDI;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_SRDJ;
					end
				end
				S_OUTRD: begin
					if (out_free) state_q <= S_OUTW;
				end
				S_OUTW: begin
					out_status <= ST_READOUT;
					out_entry <= rd_data;
					out_last <= (i_q + 1'b1 == used_q);
					if (i_q + 1'b1 == used_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_OUTRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hit flag held from search into the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) upd_found_q <= 1'b0;
		else if (state_q == S_SRCH) upd_found_q <= found;
	end

	// the update must see the found entry's data held in rd_data
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH && found |=> state_q == S_UPD)
		else $error("hit did not move to update");
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CntW'(TableDepth))
		else $error("fill count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE || out_valid)
		else $error("item left no trace");
endmodule

>>> hdl/keyed_usage_accumulator_table.sv
// keyed_usage_accumulator_table: top level of the usage table
// depends on kuat_pkg, kuat_seq, kuat_mem
//
// A record beat searches the table one entry per cycle. A readout beat runs an
// exchange sort over the entry memory, which has one read and one write port,
// then reads and emits the entries one at a time. One item is worked at a
// time; the output register lets the next beat be accepted while a result
// still waits, and that item then holds at its first result until the
// register frees up.
module keyed_usage_accumulator_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // user_name[35:0], cpu_time[59:36]
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,  // entry_name, run_count, timed_count, cpu_total
	output logic [2:0]   m_tuser,  // status
	output logic         m_tlast   // last
);
	import kuat_pkg::*;

	mem_req_t req;
	entry_t   rd_data;
	entry_t   out_entry;
	status_t  out_status;

	kuat_seq u_seq (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
		.in_name(s_tdata[35:0]), .in_time(s_tdata[59:36]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status, .out_entry, .out_last(m_tlast),
		.req, .rd_data
	);

	kuat_mem u_mem (.clk, .req, .rd_data);

	// pack result fields, lowest first
	assign m_tuser = out_status;
	assign m_tdata = {4'b0, out_entry.total, out_entry.timed, out_entry.runs,
		out_entry.name};
endmodule
